>>> hw/rtl/rossler_midpoint_step_assert.svh
// assertion macros shared by the checkers of the rossler midpoint stepper
// no dependencies; expects i_clk and i_rst_n in the including scope
`ifndef ROSSLER_MIDPOINT_STEP_ASSERT_SVH
`define ROSSLER_MIDPOINT_STEP_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define RMS_ASSERT_NEXT(LBL, ANTE, CONS) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANTE) |=> (CONS)) \
        else $error("rms check failed");

// consequent checked in the same cycle as the antecedent
`define RMS_ASSERT_NOW(LBL, ANTE, CONS) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANTE) |-> (CONS)) \
        else $error("rms check failed");

`endif

>>> hw/rtl/rms_pkg.sv
// shared types, codes and the micro-op program of the rossler midpoint stepper
// no dependencies
`timescale 1ns / 1ps

package rms_pkg;

    localparam int DW = 32;

    // configuration register indexes
    localparam logic [2:0] CFG_COEF_A = 3'd0;
    localparam logic [2:0] CFG_COEF_B = 3'd1;
    localparam logic [2:0] CFG_COEF_C = 3'd2;
    localparam logic [2:0] CFG_STEP_H = 3'd3;
    localparam logic [2:0] CFG_INIT_X = 3'd4;
    localparam logic [2:0] CFG_INIT_Y = 3'd5;
    localparam logic [2:0] CFG_INIT_Z = 3'd6;

    // operand and destination codes
    localparam logic [3:0] SEL_POS_X  = 4'd0;
    localparam logic [3:0] SEL_POS_Y  = 4'd1;
    localparam logic [3:0] SEL_POS_Z  = 4'd2;
    localparam logic [3:0] SEL_MID_X  = 4'd3;
    localparam logic [3:0] SEL_MID_Y  = 4'd4;
    localparam logic [3:0] SEL_MID_Z  = 4'd5;
    localparam logic [3:0] SEL_D_X    = 4'd6;
    localparam logic [3:0] SEL_D_Y    = 4'd7;
    localparam logic [3:0] SEL_D_Z    = 4'd8;
    localparam logic [3:0] SEL_TMP    = 4'd9;
    localparam logic [3:0] SEL_COEF_A = 4'd10;
    localparam logic [3:0] SEL_COEF_B = 4'd11;
    localparam logic [3:0] SEL_COEF_C = 4'd12;
    localparam logic [3:0] SEL_STEP_H = 4'd13;
    localparam logic [3:0] SEL_FM     = 4'd14;

    // micro-op kinds
    localparam logic [1:0] OP_MUL = 2'd0;  // product register <= a * b
    localparam logic [1:0] OP_RND = 2'd1;  // rounded product <= round(product)
    localparam logic [1:0] OP_ADD = 2'd2;  // dst <= sat(+-a +-b)

    localparam logic [5:0] LAST_UOP = 6'd33;

    typedef struct packed {
        logic [1:0] op;
        logic       half;
        logic       neg_a;
        logic       neg_b;
        logic [3:0] sel_a;
        logic [3:0] sel_b;
        logic [3:0] dst;
    } t_uop;

    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[DW-1:0];
        end
    endfunction

    function automatic t_uop mk_mul(input logic [3:0] a, input logic [3:0] b);
        t_uop u;
        u = '0;
        u.op = OP_MUL;
        u.sel_a = a;
        u.sel_b = b;
        return u;
    endfunction

    function automatic t_uop mk_rnd(input logic half);
        t_uop u;
        u = '0;
        u.op = OP_RND;
        u.half = half;
        return u;
    endfunction

    function automatic t_uop mk_add(input logic na, input logic nb, input logic [3:0] a,
                                    input logic [3:0] b, input logic [3:0] dst);
        t_uop u;
        u = '0;
        u.op = OP_ADD;
        u.neg_a = na;
        u.neg_b = nb;
        u.sel_a = a;
        u.sel_b = b;
        u.dst = dst;
        return u;
    endfunction

    // derivatives at point (px, py, pz) into d_x, d_y, d_z
    function automatic t_uop deriv_uop(input logic [2:0] j, input logic [3:0] px,
                                       input logic [3:0] py, input logic [3:0] pz);
        t_uop u;
        case (j)
            3'd0:    u = mk_add(1'b1, 1'b1, py, pz, SEL_D_X);
            3'd1:    u = mk_mul(SEL_COEF_A, py);
            3'd2:    u = mk_rnd(1'b0);
            3'd3:    u = mk_add(1'b0, 1'b0, px, SEL_FM, SEL_D_Y);
            3'd4:    u = mk_add(1'b0, 1'b1, px, SEL_COEF_C, SEL_TMP);
            3'd5:    u = mk_mul(pz, SEL_TMP);
            3'd6:    u = mk_rnd(1'b0);
            default: u = mk_add(1'b0, 1'b0, SEL_COEF_B, SEL_FM, SEL_D_Z);
        endcase
        return u;
    endfunction

    // position plus h times derivative into (qx, qy, qz)
    function automatic t_uop integ_uop(input logic [3:0] j, input logic half,
                                       input logic [3:0] qx, input logic [3:0] qy,
                                       input logic [3:0] qz);
        t_uop u;
        case (j)
            4'd0:    u = mk_mul(SEL_STEP_H, SEL_D_X);
            4'd1:    u = mk_rnd(half);
            4'd2:    u = mk_add(1'b0, 1'b0, SEL_POS_X, SEL_FM, qx);
            4'd3:    u = mk_mul(SEL_STEP_H, SEL_D_Y);
            4'd4:    u = mk_rnd(half);
            4'd5:    u = mk_add(1'b0, 1'b0, SEL_POS_Y, SEL_FM, qy);
            4'd6:    u = mk_mul(SEL_STEP_H, SEL_D_Z);
            4'd7:    u = mk_rnd(half);
            default: u = mk_add(1'b0, 1'b0, SEL_POS_Z, SEL_FM, qz);
        endcase
        return u;
    endfunction

    // full program of one advance: derivative, midpoint, derivative, full step
    function automatic t_uop uop_rom(input logic [5:0] idx);
        t_uop u;
        if (idx < 6'd8) begin
            u = deriv_uop(idx[2:0], SEL_POS_X, SEL_POS_Y, SEL_POS_Z);
        end else if (idx < 6'd17) begin
            u = integ_uop(4'(idx - 6'd8), 1'b1, SEL_MID_X, SEL_MID_Y, SEL_MID_Z);
        end else if (idx < 6'd25) begin
            u = deriv_uop(3'(idx - 6'd17), SEL_MID_X, SEL_MID_Y, SEL_MID_Z);
        end else begin
            u = integ_uop(4'(idx - 6'd25), 1'b0, SEL_POS_X, SEL_POS_Y, SEL_POS_Z);
        end
        return u;
    endfunction

endpackage

>>> hw/rtl/rms_arith.sv
// shared arithmetic unit: registered multiply, rounding shift, saturating add
// depends on rms_pkg
`timescale 1ns / 1ps

module rms_arith #(
    parameter int FRAC_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  rms_pkg::t_uop            i_uop,
    input  logic signed [31:0]       i_opa,
    input  logic signed [31:0]       i_opb,
    output logic signed [31:0]       o_fm,
    output logic signed [31:0]       o_sum
);

    localparam logic signed [63:0] RND_FULL = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< FRAC_BITS;

    logic signed [63:0] r_prod;
    logic signed [31:0] r_fm;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_rnd_in;
    logic signed [63:0] w_shift;
    logic signed [33:0] w_ea;
    logic signed [33:0] w_eb;
    logic signed [33:0] w_s;

    assign w_prod = 64'(i_opa) * 64'(i_opb);

    // round to nearest, ties up; half step uses one more fraction bit
    always_comb begin
        w_rnd_in = r_prod + (i_uop.half ? RND_HALF : RND_FULL);
        w_shift  = i_uop.half ? (w_rnd_in >>> (FRAC_BITS + 1)) : (w_rnd_in >>> FRAC_BITS);
    end

    always_comb begin
        w_ea = i_uop.neg_a ? -34'(i_opa) : 34'(i_opa);
        w_eb = i_uop.neg_b ? -34'(i_opb) : 34'(i_opb);
        w_s  = w_ea + w_eb;
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_uop.op == rms_pkg::OP_MUL) begin
            r_prod <= w_prod;
        end
        if (i_en && i_uop.op == rms_pkg::OP_RND) begin
            r_fm <= rms_pkg::sat32(w_shift);
        end
    end

    assign o_fm  = r_fm;
    assign o_sum = rms_pkg::sat32(64'(w_s));

endmodule

>>> hw/rtl/rossler_midpoint_step.sv
// rossler system stepper, explicit midpoint method in signed fixed point
// depends on rms_pkg and rms_arith
`timescale 1ns / 1ps

// usage
// - slave stream: one command per transfer, tdata[0] = restart
//   restart = 1 loads init_x/y/z into the state and clears the step count, no result
//   restart = 0 reports the step index and x, y, z, then advances one midpoint step
// - master stream: one result per advance, valid the cycle after the command transfer
// - config port: write enable, index 0..6 (coef_a, coef_b, coef_c, step_size,
//   init_x, init_y, init_z), 32-bit data; write only while idle
// - sequencing: an advance keeps the block busy after its transfer while it runs
//   its micro-ops one per cycle on the single shared multiplier/adder, and no new
//   command is taken until they are done; a restart leaves the block ready
// - stall: the result sits in an output register; the next command is taken only
//   when that register is empty or being drained in the same cycle
// - reset: synchronous, active low; config registers return to their defaults,
//   state and step count go to zero, no result pending
// - all computed values saturate to the signed 32-bit range; the step count wraps

module rossler_midpoint_step #(
    parameter int FRAC_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // command stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [0] restart, [7:1] zero
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // [31:0] step_index, [63:32] out_x,
                                           // [95:64] out_y, [127:96] out_z
    // configuration writes
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // configuration
    logic signed [31:0] r_coef_a, r_coef_b, r_coef_c;
    logic        [30:0] r_step_h;
    logic signed [31:0] r_init_x, r_init_y, r_init_z;

    // integrator state and scratch
    logic signed [31:0] r_pos_x, r_pos_y, r_pos_z;
    logic signed [31:0] r_mid_x, r_mid_y, r_mid_z;
    logic signed [31:0] r_d_x, r_d_y, r_d_z;
    logic signed [31:0] r_tmp;
    logic        [31:0] r_count;

    // sequencer
    logic               r_state;
    logic        [5:0]  r_step;

    // result register
    logic               r_ovalid;
    logic        [31:0] r_out_index;
    logic signed [31:0] r_out_x, r_out_y, r_out_z;

    rms_pkg::t_uop      w_uop;
    logic signed [31:0] w_opa, w_opb, w_fm, w_sum;
    logic               w_in_fire;
    logic               w_restart;
    logic               w_run;
    logic               w_wb;

    assign w_run     = (r_state == ST_RUN);
    assign w_uop     = rms_pkg::uop_rom(r_step);
    assign w_restart = i_s_axis_tdata[0];

    // take a command only when idle and the result register can accept a new entry
    assign o_s_axis_tready = !w_run && (!r_ovalid || i_m_axis_tready);
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_wb            = w_run && (w_uop.op == rms_pkg::OP_ADD);

    function automatic logic signed [31:0] pick(input logic [3:0] sel,
            input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz, input logic signed [31:0] mx,
            input logic signed [31:0] my, input logic signed [31:0] mz,
            input logic signed [31:0] dx, input logic signed [31:0] dy,
            input logic signed [31:0] dz, input logic signed [31:0] tmp,
            input logic signed [31:0] ca, input logic signed [31:0] cb,
            input logic signed [31:0] cc, input logic [30:0] h,
            input logic signed [31:0] fm);
        logic signed [31:0] v;
        unique case (sel)
            rms_pkg::SEL_POS_X:  v = px;
            rms_pkg::SEL_POS_Y:  v = py;
            rms_pkg::SEL_POS_Z:  v = pz;
            rms_pkg::SEL_MID_X:  v = mx;
            rms_pkg::SEL_MID_Y:  v = my;
            rms_pkg::SEL_MID_Z:  v = mz;
            rms_pkg::SEL_D_X:    v = dx;
            rms_pkg::SEL_D_Y:    v = dy;
            rms_pkg::SEL_D_Z:    v = dz;
            rms_pkg::SEL_TMP:    v = tmp;
            rms_pkg::SEL_COEF_A: v = ca;
            rms_pkg::SEL_COEF_B: v = cb;
            rms_pkg::SEL_COEF_C: v = cc;
            rms_pkg::SEL_STEP_H: v = {1'b0, h};   // h is non-negative
            rms_pkg::SEL_FM:     v = fm;
            default:             v = '0;
        endcase
        return v;
    endfunction

    assign w_opa = pick(w_uop.sel_a, r_pos_x, r_pos_y, r_pos_z, r_mid_x, r_mid_y, r_mid_z,
                        r_d_x, r_d_y, r_d_z, r_tmp, r_coef_a, r_coef_b, r_coef_c,
                        r_step_h, w_fm);
    assign w_opb = pick(w_uop.sel_b, r_pos_x, r_pos_y, r_pos_z, r_mid_x, r_mid_y, r_mid_z,
                        r_d_x, r_d_y, r_d_z, r_tmp, r_coef_a, r_coef_b, r_coef_c,
                        r_step_h, w_fm);

    rms_arith #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .i_clk (i_clk),
        .i_en  (w_run),
        .i_uop (w_uop),
        .i_opa (w_opa),
        .i_opb (w_opb),
        .o_fm  (w_fm),
        .o_sum (w_sum)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= 32'sd2516582;     // 0.15
            r_coef_b <= 32'sd3355443;     // 0.20
            r_coef_c <= 32'sd119118234;   // 7.10
            r_step_h <= 31'd16777;        // 0.001
            r_init_x <= '0;
            r_init_y <= '0;
            r_init_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rms_pkg::CFG_COEF_A: r_coef_a <= i_cfg_wdata;
                rms_pkg::CFG_COEF_B: r_coef_b <= i_cfg_wdata;
                rms_pkg::CFG_COEF_C: r_coef_c <= i_cfg_wdata;
                rms_pkg::CFG_STEP_H: r_step_h <= i_cfg_wdata[30:0];
                rms_pkg::CFG_INIT_X: r_init_x <= i_cfg_wdata;
                rms_pkg::CFG_INIT_Y: r_init_y <= i_cfg_wdata;
                rms_pkg::CFG_INIT_Z: r_init_z <= i_cfg_wdata;
                default: ;   // index past the list is dropped
            endcase
        end
    end

    // sequencer, state and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_count <= '0;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        if (w_restart) begin
                            r_pos_x <= r_init_x;
                            r_pos_y <= r_init_y;
                            r_pos_z <= r_init_z;
                            r_count <= '0;
                        end else begin
                            r_state <= ST_RUN;
                            r_step  <= '0;
                        end
                    end
                end
                ST_RUN: begin
                    // final step writes back the position, the only state update
                    if (w_wb && w_uop.dst == rms_pkg::SEL_POS_X) r_pos_x <= w_sum;
                    if (w_wb && w_uop.dst == rms_pkg::SEL_POS_Y) r_pos_y <= w_sum;
                    if (w_wb && w_uop.dst == rms_pkg::SEL_POS_Z) r_pos_z <= w_sum;
                    if (r_step == rms_pkg::LAST_UOP) begin
                        r_state <= ST_IDLE;
                        r_count <= r_count + 32'd1;
                    end else begin
                        r_step <= r_step + 6'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // scratch registers, written only by the add micro-op
    always_ff @(posedge i_clk) begin
        if (w_wb) begin
            case (w_uop.dst)
                rms_pkg::SEL_MID_X: r_mid_x <= w_sum;
                rms_pkg::SEL_MID_Y: r_mid_y <= w_sum;
                rms_pkg::SEL_MID_Z: r_mid_z <= w_sum;
                rms_pkg::SEL_D_X:   r_d_x   <= w_sum;
                rms_pkg::SEL_D_Y:   r_d_y   <= w_sum;
                rms_pkg::SEL_D_Z:   r_d_z   <= w_sum;
                rms_pkg::SEL_TMP:   r_tmp   <= w_sum;
                default: ;
            endcase
        end
    end

    // result register: snapshot of the state before the step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_in_fire && !w_restart) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && !w_restart) begin
            r_out_index <= r_count;
            r_out_x     <= r_pos_x;
            r_out_y     <= r_pos_y;
            r_out_z     <= r_pos_z;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_out_z, r_out_y, r_out_x, r_out_index};

endmodule

>>> hw/rtl/rms_chk.sv
// port-level checker for the rossler midpoint stepper, bound to the top level
// depends on rossler_midpoint_step_assert.svh and rossler_midpoint_step
`timescale 1ns / 1ps
`include "rossler_midpoint_step_assert.svh"

module rms_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         i_restart,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [127:0] o_m_axis_tdata
);

    logic w_in_fire;
    logic w_out_stall;

    assign w_in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    // stalled result holds
    `RMS_ASSERT_NEXT(a_out_hold, w_out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // an advance shows its result next cycle and keeps the block busy
    `RMS_ASSERT_NEXT(a_adv_result, w_in_fire && !i_restart, o_m_axis_tvalid && !o_s_axis_tready)

    // a restart gives no result and leaves the block ready
    `RMS_ASSERT_NEXT(a_restart_quiet, w_in_fire && i_restart, !o_m_axis_tvalid && o_s_axis_tready)

    // a command is taken only when the result register has room
    `RMS_ASSERT_NOW(a_ready_room, o_s_axis_tready, !o_m_axis_tvalid || i_m_axis_tready)

endmodule

bind rossler_midpoint_step rms_chk u_rms_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_restart       (i_s_axis_tdata[0]),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> tb/testbench.sv
// self-checking bench for the rossler midpoint stepper: a bit-exact predictor of the
// saturating fixed-point integrator scores every result transfer against the stream
// depends on rms_pkg and rossler_midpoint_step
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC = 24;
    // cap on the whole run, with ample margin over the slowest legal run
    localparam int CYCLE_LIMIT = 750000;
    // wait after idle, longer than an advance keeps the block busy after its command transfer
    localparam int SETTLE = 40;
    // index past the end of the register file, writes to it must be dropped
    localparam logic [2:0] CFG_NONE = 3'd7;

    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] W_MAX = 32'h7fff_ffff;

    typedef struct {
        logic restart;
        logic drain;    // hold this command until every expected result is out
    } t_cmd;

    typedef struct {
        logic [31:0]        idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_orbit_sample;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cmd_valid = 1'b0;
    logic         cmd_ready;
    logic [7:0]   cmd_data = '0;
    logic         res_valid;
    logic         res_ready = 1'b1;
    logic [127:0] res_data;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    // register copies, reset values
    logic signed [31:0] cur_a = 32'sd2516582;
    logic signed [31:0] cur_b = 32'sd3355443;
    logic signed [31:0] cur_c = 32'sd119118234;
    logic [30:0]        cur_h = 31'd16777;
    logic signed [31:0] cur_ix = '0;
    logic signed [31:0] cur_iy = '0;
    logic signed [31:0] cur_iz = '0;

    // integrator state copy
    logic signed [31:0] st_x = '0;
    logic signed [31:0] st_y = '0;
    logic signed [31:0] st_z = '0;
    logic [31:0]        st_count = '0;

    t_cmd          pending_cmds[$];
    t_orbit_sample expected_samples[$];
    bit            failed = 1'b0;
    int            cycle_count = 0;
    int            tx_gap = 0;
    int            tx_burst = 1;
    int            rx_tick = 0;
    int            rx_hold = 0;

    rossler_midpoint_step #(
        .FRAC_BITS(FRAC)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(cmd_valid),
        .o_s_axis_tready(cmd_ready),
        .i_s_axis_tdata (cmd_data),
        .o_m_axis_tvalid(res_valid),
        .i_m_axis_tready(res_ready),
        .o_m_axis_tdata (res_data),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_add(input longint p, input longint q);
        return clamp32(p + q);
    endfunction

    // full product, round half up at bit k-1, arithmetic shift, saturate
    function automatic logic signed [31:0] qmul(input longint p, input longint q, input int k);
        longint prod;
        prod = p * q + (longint'(1) << (k - 1));
        return clamp32(prod >>> k);
    endfunction

    function automatic void rossler_rates(input logic signed [31:0] x, y, z,
                                          output logic signed [31:0] dx, dy, dz);
        dx = clamp32(-longint'(y) - longint'(z));
        dy = sat_add(x, qmul(cur_a, y, FRAC));
        dz = sat_add(cur_b, qmul(z, sat_add(x, -longint'(cur_c)), FRAC));
    endfunction

    // one command into the state copy; an advance queues the sample it reports
    function automatic void apply_command(input logic restart);
        logic signed [31:0] dx, dy, dz, mx, my, mz;
        longint             h;
        t_orbit_sample      s;
        h = longint'({1'b0, cur_h});
        if (restart) begin
            st_x = cur_ix;
            st_y = cur_iy;
            st_z = cur_iz;
            st_count = '0;
        end else begin
            s.idx = st_count;
            s.x = st_x;
            s.y = st_y;
            s.z = st_z;
            expected_samples.push_back(s);
            // half step uses one extra shift so the odd bit of h survives
            rossler_rates(st_x, st_y, st_z, dx, dy, dz);
            mx = sat_add(st_x, qmul(h, dx, FRAC + 1));
            my = sat_add(st_y, qmul(h, dy, FRAC + 1));
            mz = sat_add(st_z, qmul(h, dz, FRAC + 1));
            rossler_rates(mx, my, mz, dx, dy, dz);
            st_x = sat_add(st_x, qmul(h, dx, FRAC));
            st_y = sat_add(st_y, qmul(h, dy, FRAC));
            st_z = sat_add(st_z, qmul(h, dz, FRAC));
            st_count = st_count + 32'd1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------- command driver

    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
        end else begin
            if (cmd_valid && cmd_ready) begin
                apply_command(cmd_data[0]);
            end
            if (!cmd_valid || cmd_ready) begin
                if (tx_gap != 0) begin
                    tx_gap = tx_gap - 1;
                    cmd_valid <= 1'b0;
                end else if (pending_cmds.size() != 0 &&
                             !(pending_cmds[0].drain && expected_samples.size() != 0)) begin
                    cmd_valid <= 1'b1;
                    cmd_data <= {7'd0, pending_cmds[0].restart};
                    void'(pending_cmds.pop_front());
                    tx_burst = tx_burst - 1;
                    if (tx_burst <= 0) begin
                        tx_burst = $urandom_range(1, 24);
                        // about a third of the bursts run straight into the next
                        tx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
                    end
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result monitor

    always @(posedge clk) begin
        if (rst_n) begin
            if (res_valid && res_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("result transfer with nothing expected: %h", res_data);
                    failed = 1'b1;
                end else begin
                    check_field("step_index", expected_samples[0].idx, res_data[31:0]);
                    check_field("out_x", expected_samples[0].x, res_data[63:32]);
                    check_field("out_y", expected_samples[0].y, res_data[95:64]);
                    check_field("out_z", expected_samples[0].z, res_data[127:96]);
                    void'(expected_samples.pop_front());
                end
            end
            // stall pattern changes character with bits 10:9 of the tick counter
            rx_tick = rx_tick + 1;
            case (rx_tick[10:9])
                2'd0: begin
                    res_ready <= 1'b1;
                end
                2'd1: begin
                    res_ready <= ($urandom_range(0, 3) != 0);
                end
                2'd2: begin
                    if (rx_hold != 0) begin
                        rx_hold = rx_hold - 1;
                        res_ready <= 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        rx_hold = $urandom_range(1, 40);
                        res_ready <= 1'b0;
                    end else begin
                        res_ready <= 1'b1;
                    end
                end
                default: begin
                    // square wave that drifts against the step period of the advances
                    res_ready <= rx_tick[2];
                end
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequencing

    // block is idle once nothing is queued or expected and it is ready for a command;
    // sampled at the falling edge so every clocked update has settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || !cmd_ready ||
               expected_samples.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            rms_pkg::CFG_COEF_A: cur_a = val;
            rms_pkg::CFG_COEF_B: cur_b = val;
            rms_pkg::CFG_COEF_C: cur_c = val;
            rms_pkg::CFG_STEP_H: cur_h = val[30:0];
            rms_pkg::CFG_INIT_X: cur_ix = val;
            rms_pkg::CFG_INIT_Y: cur_iy = val;
            rms_pkg::CFG_INIT_Z: cur_iz = val;
            default: ;
        endcase
    endtask

    task automatic load_regs(input logic [31:0] a, b, c, h, ix, iy, iz, input bit junk);
        wait_idle();
        write_reg(rms_pkg::CFG_COEF_A, a);
        write_reg(rms_pkg::CFG_COEF_B, b);
        write_reg(rms_pkg::CFG_COEF_C, c);
        write_reg(rms_pkg::CFG_STEP_H, h);
        write_reg(rms_pkg::CFG_INIT_X, ix);
        write_reg(rms_pkg::CFG_INIT_Y, iy);
        write_reg(rms_pkg::CFG_INIT_Z, iz);
        if (junk) begin
            write_reg(CFG_NONE, $urandom());
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_cmd(input logic restart, input logic drain);
        t_cmd c;
        c.restart = restart;
        c.drain = drain;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_run(input int advances, input logic drain);
        queue_cmd(1'b1, drain);
        repeat (advances) queue_cmd(1'b0, 1'b0);
    endtask

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 5))
            0: return W_MIN;
            1: return W_MAX;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return 32'h1;
            default: return $urandom();
        endcase
    endfunction

    // one random register setting: near the classic orbit, raw, corners, or mixed
    task automatic random_setting();
        logic [31:0] v [0:6];
        int          style;
        style = $urandom_range(0, 3);
        for (int i = 0; i < 7; i++) begin
            case (style)
                0: v[i] = 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
                1: v[i] = $urandom();
                2: v[i] = corner_word();
                default: v[i] = (i < 3) ? $urandom() : 32'($urandom_range(0, 32'h0400_0000));
            endcase
        end
        if (style == 0) begin
            v[0] = 32'd2516582 + 32'($urandom_range(0, 8388608)) - 32'd4194304;
            v[1] = 32'd3355443 + 32'($urandom_range(0, 8388608)) - 32'd4194304;
            v[2] = 32'd119118234 + 32'($urandom_range(0, 67108864)) - 32'd33554432;
            v[3] = $urandom_range(1000, 4194304);
        end else if (style == 3) begin
            v[3] = $urandom_range(0, 65536);
        end
        load_regs(v[0], v[1], v[2], v[3], v[4], v[5], v[6], $urandom_range(0, 3) == 0);
    endtask

    initial begin
        int queued;
        int kind;
        int run;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers; advancing before any restart integrates from zero
        repeat (3) queue_cmd(1'b0, 1'b0);
        queue_cmd(1'b1, 1'b0);
        queue_cmd(1'b0, 1'b0);
        queue_cmd(1'b0, 1'b1);

        // every register at an extreme, step size written with its dead top bit set,
        // plus a write to the unused index; saturation on every path
        load_regs(W_MAX, W_MIN, W_MAX, 32'hffff_ffff, W_MIN, W_MAX, W_MAX, 1'b1);
        queue_run(3, 1'b0);
        queue_cmd(1'b1, 1'b0);
        queue_cmd(1'b1, 1'b0);
        queue_cmd(1'b0, 1'b0);

        // zero step: state frozen while the count still moves
        load_regs(W_MIN, W_MIN, W_MIN, 32'h0, W_MAX, W_MIN, W_MIN, 1'b0);
        queue_run(2, 1'b0);

        // smallest odd step, exercises the rounding of the half step
        load_regs(32'hffff_ffff, 32'h1, 32'h0, 32'h1, 32'h1, 32'hffff_ffff, 32'h0, 1'b0);
        queue_run(2, 1'b0);

        // random settings, mostly restart followed by a run of advances
        for (int p = 0; p < 10; p++) begin
            random_setting();
            queued = 0;
            while (queued < 100) begin
                kind = $urandom_range(0, 9);
                if (kind <= 6) begin
                    run = $urandom_range(1, 30);
                    queue_run(run, $urandom_range(0, 19) == 0);
                    queued = queued + run + 1;
                end else if (kind <= 8) begin
                    queue_cmd(1'b0, 1'b0);
                    queued = queued + 1;
                end else begin
                    queue_cmd(1'b1, 1'b0);
                    queue_cmd(1'b1, 1'b0);
                    queued = queued + 2;
                end
            end
        end

        wait_idle();
        if (!failed) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/rms_pkg.sv
hw/rtl/rms_arith.sv
hw/rtl/rossler_midpoint_step.sv
hw/rtl/rms_chk.sv
tb/testbench.sv
